@@ sv/arg_pkg.sv @@
// -----------------------------------------------------------------------------
// arg_pkg
// Shared types and constants of the audio ring with grain clock: operation
// kinds, register indexes, reset values and the per-item status record.
// -----------------------------------------------------------------------------
package arg_pkg;

   // Default sizing
   localparam int RING_DEPTH_DEF   = 65536;
   localparam int GRAIN_FRAMES_DEF = 256;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int CLOCK_W  = 48;
   localparam int DEBT_W   = 16;
   localparam int STEP_W   = 8;
   localparam int COUNT_W  = 32;
   localparam int KIND_W   = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBT_CAP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPAY_STEP = 2'd1;

   // Register reset values: 500 ms at 48 kHz, and 16 frames per grain
   localparam logic [DEBT_W-1:0] DEBT_CAP_RESET   = 16'd24000;
   localparam logic [STEP_W-1:0] REPAY_STEP_RESET = 8'd16;

   // Operation kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE      = 3'd0,
      KIND_PULL       = 3'd1,
      KIND_FLUSH      = 3'd2,
      KIND_SET_BASE   = 3'd3,
      KIND_RESET_BASE = 3'd4,
      KIND_SET_PAUSE  = 3'd5
   } kind_type;

   // Status of one item after it has been applied
   typedef struct packed {
      logic               deliver;
      logic               is_padding;
      logic               grain_end;
      logic               write_dropped;
      logic [CLOCK_W-1:0] clock_frames;
      logic               clock_valid;
      logic [DEBT_W-1:0]  debt_level;
      logic [COUNT_W-1:0] underrun_count;
      logic [COUNT_W-1:0] drop_count;
   } status_type;

endpackage

@@ sv/arg_ring_mem.sv @@
// -----------------------------------------------------------------------------
// arg_ring_mem
// Frame store of the ring: one write port and one read port, read data
// registered and held between reads.
// -----------------------------------------------------------------------------
module arg_ring_mem #(
   parameter int DEPTH = arg_pkg::RING_DEPTH_DEF,
   parameter int WIDTH = arg_pkg::FRAME_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Store a frame
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Fetch a frame, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/arg_ctrl.sv @@
// -----------------------------------------------------------------------------
// arg_ctrl
// Ring pointers, grain sequencing, clock, debt and counters. Applies one
// item per transfer, drives the frame store and reports the new status.
// -----------------------------------------------------------------------------
module arg_ctrl #(
   parameter int RING_DEPTH   = arg_pkg::RING_DEPTH_DEF,
   parameter int GRAIN_FRAMES = arg_pkg::GRAIN_FRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // item
   input  logic                               accept,
   input  logic [arg_pkg::KIND_W-1:0]         kind,
   input  logic [arg_pkg::SAMPLE_W-1:0]       in_left,
   input  logic [arg_pkg::SAMPLE_W-1:0]       in_right,
   input  logic [arg_pkg::CLOCK_W-1:0]        pts_frames,
   input  logic                               pause_flag,
   // configuration
   input  logic                               csr_write_en,
   input  logic [arg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arg_pkg::CSR_DATA_W-1:0]     csr_data,
   // frame store
   output logic                               mem_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]      mem_wr_addr,
   output logic [arg_pkg::FRAME_W-1:0]        mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]      mem_rd_addr,
   // status after the item
   output arg_pkg::status_type                status,
   output logic [$clog2(RING_DEPTH+1)-1:0]    fill_level
);

   import arg_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int PW = $clog2(GRAIN_FRAMES);
   localparam int VW = $clog2(GRAIN_FRAMES + 1);

   // State
   logic [AW-1:0]      head_ff, head_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [VW-1:0]      avail_ff, avail_in;
   logic               paused_ff, paused_in;
   logic [CLOCK_W-1:0] clock_ff, clock_in;
   logic               base_set_ff, base_set_in;
   logic [DEBT_W-1:0]  debt_ff, debt_in;
   logic [COUNT_W-1:0] underruns_ff, underruns_in;
   logic [COUNT_W-1:0] drops_ff, drops_in;
   logic [DEBT_W-1:0]  debt_cap_ff;
   logic [STEP_W-1:0]  repay_step_ff;

   // Working values
   logic [AW:0]        wr_sum;
   logic [VW-1:0]      avail_cur;
   logic               deliver;
   logic               last_pull;
   logic [DEBT_W:0]    debt_sum;
   logic [STEP_W-1:0]  step;
   logic               is_padding;
   logic               dropped;

   // Apply one item
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      avail_in     = avail_ff;
      paused_in    = paused_ff;
      clock_in     = clock_ff;
      base_set_in  = base_set_ff;
      debt_in      = debt_ff;
      underruns_in = underruns_ff;
      drops_in     = drops_ff;
      deliver      = 1'b0;
      is_padding   = 1'b0;
      dropped      = 1'b0;
      last_pull    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      step         = '0;
      debt_sum     = '0;

      // Write slot: head plus fill, wrapped once
      wr_sum = (AW+1)'(head_ff) + (AW+1)'(fill_ff);
      if (32'(wr_sum) >= RING_DEPTH) begin
         wr_sum = wr_sum - (AW+1)'(RING_DEPTH);
      end
      mem_wr_addr = wr_sum[AW-1:0];
      mem_wr_data = {in_right, in_left};
      mem_rd_addr = head_ff;

      // Frames granted to this grain: latch at its first pull
      avail_cur = avail_ff;
      if (pos_ff == '0) begin
         if (paused_ff) begin
            avail_cur = '0;
         end else if (32'(fill_ff) < GRAIN_FRAMES) begin
            avail_cur = VW'(fill_ff);
         end else begin
            avail_cur = VW'(GRAIN_FRAMES);
         end
      end

      case (kind_type'(kind))
         KIND_WRITE: begin
            if (32'(fill_ff) >= RING_DEPTH) begin
               dropped  = 1'b1;
               drops_in = (drops_ff == '1) ? drops_ff : drops_ff + 1'b1;
            end else begin
               mem_wr_en = accept;
               fill_in   = fill_ff + 1'b1;
            end
         end
         KIND_PULL: begin
            avail_in = avail_cur;
            if ((32'(pos_ff) < 32'(avail_cur)) && (fill_ff != '0)) begin
               deliver   = 1'b1;
               mem_rd_en = accept;
               head_in   = (32'(head_ff) == RING_DEPTH - 1) ? '0 : head_ff + 1'b1;
               fill_in   = fill_ff - 1'b1;
            end else begin
               is_padding = 1'b1;
            end
            // Close the grain
            if (pos_ff == PW'(GRAIN_FRAMES - 1)) begin
               last_pull = 1'b1;
               pos_in    = '0;
               if (!paused_ff) begin
                  clock_in = clock_ff + CLOCK_W'(GRAIN_FRAMES);
                  if (avail_cur < VW'(GRAIN_FRAMES)) begin
                     underruns_in = (underruns_ff == '1) ? underruns_ff
                                                         : underruns_ff + 1'b1;
                     debt_sum = (DEBT_W+1)'(debt_ff)
                              + (DEBT_W+1)'(VW'(GRAIN_FRAMES) - avail_cur);
                     debt_in  = (debt_sum > {1'b0, debt_cap_ff}) ? debt_cap_ff
                                                                 : debt_sum[DEBT_W-1:0];
                  end else if (debt_ff != '0) begin
                     step     = (debt_ff < DEBT_W'(repay_step_ff)) ? debt_ff[STEP_W-1:0]
                                                                   : repay_step_ff;
                     debt_in  = debt_ff - DEBT_W'(step);
                     clock_in = clock_ff + CLOCK_W'(GRAIN_FRAMES) - CLOCK_W'(step);
                  end
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         KIND_FLUSH: begin
            head_in     = '0;
            fill_in     = '0;
            clock_in    = '0;
            base_set_in = 1'b0;
            debt_in     = '0;
            if (32'(avail_ff) > 32'(pos_ff)) begin
               avail_in = VW'(pos_ff);
            end
         end
         KIND_SET_BASE: begin
            if (!base_set_ff) begin
               clock_in    = pts_frames;
               base_set_in = 1'b1;
            end
         end
         KIND_RESET_BASE: begin
            clock_in    = pts_frames;
            base_set_in = 1'b1;
         end
         KIND_SET_PAUSE: begin
            paused_in = pause_flag;
         end
         default: begin
         end
      endcase
   end

   // Hold state, advance on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         avail_ff     <= '0;
         paused_ff    <= 1'b0;
         clock_ff     <= '0;
         base_set_ff  <= 1'b0;
         debt_ff      <= '0;
         underruns_ff <= '0;
         drops_ff     <= '0;
      end else if (accept) begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         avail_ff     <= avail_in;
         paused_ff    <= paused_in;
         clock_ff     <= clock_in;
         base_set_ff  <= base_set_in;
         debt_ff      <= debt_in;
         underruns_ff <= underruns_in;
         drops_ff     <= drops_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debt_cap_ff   <= DEBT_CAP_RESET;
         repay_step_ff <= REPAY_STEP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBT_CAP:   debt_cap_ff   <= csr_data;
            CSR_REPAY_STEP: repay_step_ff <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Report the status after the item
   always_comb begin
      status.deliver        = deliver;
      status.is_padding     = is_padding;
      status.grain_end      = last_pull;
      status.write_dropped  = dropped;
      status.clock_frames   = clock_in;
      status.clock_valid    = base_set_in;
      status.debt_level     = debt_in;
      status.underrun_count = underruns_in;
      status.drop_count     = drops_in;
   end

   assign fill_level = fill_in;

endmodule

@@ sv/audio_ring_grain_clock.sv @@
// -----------------------------------------------------------------------------
// audio_ring_grain_clock
// Stereo output ring with a frame-counted A/V clock, grain-based delivery,
// underrun padding and debt repayment.
// -----------------------------------------------------------------------------
// One request enters per clock while req_stall is low, and every request
// gives exactly one response. The frame store read of a pull and the status
// capture share the first stage, the output register is the second, and a
// response is offered once it reaches the output register. Because the first
// stage can hold a response while the output register waits, the block still
// takes one request while a response is stalled and stalls the request side
// only when both stages are full.
// The frame store needs no clearing pass after reset: only entries that were
// written are ever delivered. Configuration writes take effect at once and
// are meant for idle periods.
module audio_ring_grain_clock #(
   parameter int RING_DEPTH   = arg_pkg::RING_DEPTH_DEF,
   parameter int GRAIN_FRAMES = arg_pkg::GRAIN_FRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // requests
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [arg_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [arg_pkg::SAMPLE_W-1:0] req_in_left,
   input  logic signed [arg_pkg::SAMPLE_W-1:0] req_in_right,
   input  logic signed [arg_pkg::CLOCK_W-1:0] req_pts_frames,
   input  logic                               req_pause_flag,
   // responses
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [arg_pkg::SAMPLE_W-1:0] rsp_out_left,
   output logic signed [arg_pkg::SAMPLE_W-1:0] rsp_out_right,
   output logic                               rsp_is_padding,
   output logic                               rsp_grain_end,
   output logic                               rsp_write_dropped,
   output logic [$clog2(RING_DEPTH+1)-1:0]    rsp_fill_level,
   output logic signed [arg_pkg::CLOCK_W-1:0] rsp_clock_frames,
   output logic                               rsp_clock_valid,
   output logic [arg_pkg::DEBT_W-1:0]         rsp_debt_level,
   output logic [arg_pkg::COUNT_W-1:0]        rsp_underrun_count,
   output logic [arg_pkg::COUNT_W-1:0]        rsp_drop_count,
   // configuration
   input  logic                               csr_write_en,
   input  logic [arg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arg_pkg::CSR_DATA_W-1:0]     csr_data
);

   import arg_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);

   logic               accept;
   logic               s1_move;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [FRAME_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [FRAME_W-1:0] mem_rd_data;
   status_type         status;
   logic [FW-1:0]      fill_level;

   // Pipeline registers
   logic               s1_valid_ff, s1_valid_in;
   status_type         s1_stat_ff;
   logic [FW-1:0]      s1_fill_ff;
   logic               out_valid_ff, out_valid_in;
   status_type         out_stat_ff;
   logic [FW-1:0]      out_fill_ff;
   logic [SAMPLE_W-1:0] out_left_ff, out_left_in;
   logic [SAMPLE_W-1:0] out_right_ff, out_right_in;

   arg_ctrl #(
      .RING_DEPTH   (RING_DEPTH),
      .GRAIN_FRAMES (GRAIN_FRAMES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .in_left      (req_in_left),
      .in_right     (req_in_right),
      .pts_frames   (req_pts_frames),
      .pause_flag   (req_pause_flag),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .status       (status),
      .fill_level   (fill_level)
   );

   arg_ring_mem #(
      .DEPTH (RING_DEPTH),
      .WIDTH (FRAME_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Handshake: stall only when both stages hold a response
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // Zero the samples unless a stored frame was delivered
      out_left_in  = s1_stat_ff.deliver ? mem_rd_data[SAMPLE_W-1:0] : '0;
      out_right_in = s1_stat_ff.deliver ? mem_rd_data[FRAME_W-1:SAMPLE_W] : '0;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture status on transfer, move it forward with the read data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= status;
         s1_fill_ff <= fill_level;
      end
      if (s1_move) begin
         out_stat_ff  <= s1_stat_ff;
         out_fill_ff  <= s1_fill_ff;
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_left       = out_left_ff;
   assign rsp_out_right      = out_right_ff;
   assign rsp_is_padding     = out_stat_ff.is_padding;
   assign rsp_grain_end      = out_stat_ff.grain_end;
   assign rsp_write_dropped  = out_stat_ff.write_dropped;
   assign rsp_fill_level     = out_fill_ff;
   assign rsp_clock_frames   = out_stat_ff.clock_frames;
   assign rsp_clock_valid    = out_stat_ff.clock_valid;
   assign rsp_debt_level     = out_stat_ff.debt_level;
   assign rsp_underrun_count = out_stat_ff.underrun_count;
   assign rsp_drop_count     = out_stat_ff.drop_count;

   // Request side waits only behind a full pipeline
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff))
      else $error("request stalled with a free pipeline stage");

   // Padded frames are silent
   a_pad_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_padding) |-> (rsp_out_left == '0 && rsp_out_right == '0))
      else $error("padding frame carries sample data");

   // A response is never both a grain end and a dropped write
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_grain_end && rsp_write_dropped))
      else $error("grain end and write drop on one response");

   // Fill never exceeds the ring
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_fill_level) <= RING_DEPTH))
      else $error("fill level beyond ring depth");

endmodule
